// ----- design/kts_pkg.sv -----
// ----------------------------------------------------------------------------
// Keyframe selection package
// Shared types, register codes and helpers of the keyframe time/distance
// selector.
// ----------------------------------------------------------------------------
package kts_pkg;

  localparam int unsigned TS_W    = 63;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned LEVEL_W = 3;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned TGAP_W  = 40;
  localparam int unsigned DIST_W  = 31;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned ADDR_W  = 4;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 3'd7;

  localparam logic [TGAP_W-1:0] TGAP_RESET = 40'd1000000000;
  localparam logic [DIST_W-1:0] DIST_RESET = 31'd65536;

  // Register select taken from address bit three.
  localparam logic REG_TIME_GAP = 1'b0;
  localparam logic REG_DISTANCE = 1'b1;

  typedef struct packed {
    logic                    in_range;
    logic                    valid;
    logic [TS_W-1:0]         ts;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } ref_entry_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               stored;
    logic               first;
  } decision_t;

  function automatic logic [LEVEL_W-1:0] raise_level(input logic [LEVEL_W-1:0] lvl);
    return (lvl == LEVEL_MAX) ? LEVEL_MAX : LEVEL_W'(lvl + 1'b1);
  endfunction

endpackage

// ----- design/keyframe_time_distance_select.sv -----
// ----------------------------------------------------------------------------
// Keyframe time/distance selector
// Marks poses as keyframes by time gap and travelled distance per trajectory.
// ----------------------------------------------------------------------------
// A pose request is taken into an input register and its decision reaches the
// result register at the edge on which it advances, which waits while a held
// result is not taken; one request can be taken every cycle while the result
// side does not stall. The reference table read, both tests and the table
// update all happen between the two registers, in the cycle the request
// advances, which allows a pose to follow a pose of the same trajectory with
// no gap. The thresholds sit at byte addresses 0 and 8 of the 64-bit
// configuration port and should only be written while no request is in flight.
module keyframe_time_distance_select import kts_pkg::*; #(
  parameter int unsigned TRAJ_COUNT = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [IDX_W-1:0]        trajectory_index_i,
  input  logic [LEVEL_W-1:0]      level_in_i,
  input  logic [TS_W-1:0]         timestamp_ns_i,
  input  logic signed [POS_W-1:0] position_x_i,
  input  logic signed [POS_W-1:0] position_y_i,
  input  logic signed [POS_W-1:0] position_z_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [LEVEL_W-1:0]      level_out_o,
  output logic                    became_reference_o,
  output logic                    first_of_trajectory_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [CFG_W-1:0]        pwdata,
  output logic [CFG_W-1:0]        prdata,
  output logic                    pready
);

  logic [TGAP_W-1:0]       tgap_thr_q;
  logic [DIST_W-1:0]       dist_thr_q;
  logic                    s1_valid_q;
  logic [IDX_W-1:0]        s1_idx_q;
  logic [LEVEL_W-1:0]      s1_level_q;
  logic [TS_W-1:0]         s1_ts_q;
  logic signed [POS_W-1:0] s1_x_q, s1_y_q, s1_z_q;
  logic                    out_valid_q;
  decision_t               out_q;
  logic                    advance;
  logic                    cfg_write;
  ref_entry_t              entry;
  decision_t               dec;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[3] == REG_DISTANCE) ? CFG_W'(dist_thr_q) : CFG_W'(tgap_thr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgap_thr_q <= TGAP_RESET;
      dist_thr_q <= DIST_RESET;
    end else if (cfg_write) begin
      if (paddr[3] == REG_TIME_GAP) begin
        tgap_thr_q <= pwdata[TGAP_W-1:0];
      end else begin
        dist_thr_q <= pwdata[DIST_W-1:0];
      end
    end
  end

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_idx_q   <= trajectory_index_i;
      s1_level_q <= level_in_i;
      s1_ts_q    <= timestamp_ns_i;
      s1_x_q     <= position_x_i;
      s1_y_q     <= position_y_i;
      s1_z_q     <= position_z_i;
    end
    if (advance) begin
      out_q <= dec;
    end
  end

  kts_table #(
    .TRAJ_COUNT(TRAJ_COUNT)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .idx_i   (s1_idx_q),
    .wr_en_i (advance && dec.stored),
    .wr_ts_i (s1_ts_q),
    .wr_x_i  (s1_x_q),
    .wr_y_i  (s1_y_q),
    .wr_z_i  (s1_z_q),
    .entry_o (entry)
  );

  kts_decide u_decide (
    .level_i    (s1_level_q),
    .ts_i       (s1_ts_q),
    .x_i        (s1_x_q),
    .y_i        (s1_y_q),
    .z_i        (s1_z_q),
    .entry_i    (entry),
    .tgap_thr_i (tgap_thr_q),
    .dist_thr_i (dist_thr_q),
    .dec_o      (dec)
  );

  assign out_valid_o           = out_valid_q;
  assign level_out_o           = out_q.level;
  assign became_reference_o    = out_q.stored;
  assign first_of_trajectory_o = out_q.first;

  // A first pose of a trajectory is always stored as its reference.
  a_first_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && first_of_trajectory_o |-> became_reference_o)
    else $error("first pose not stored as reference");

  // A later promotion only happens from level zero, giving level one.
  a_promote_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && became_reference_o && !first_of_trajectory_o |-> level_out_o == 3'd1)
    else $error("promoted pose has wrong level");

  // A request leaving the input register always lands in the result register.
  a_advance_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("decided request lost");

endmodule

// ----- design/kts_table.sv -----
// ----------------------------------------------------------------------------
// Keyframe reference table
// One reference keyframe per trajectory, with valid marks cleared at reset.
// ----------------------------------------------------------------------------
module kts_table import kts_pkg::*; #(
  parameter int unsigned TRAJ_COUNT = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [IDX_W-1:0]        idx_i,
  input  logic                    wr_en_i,
  input  logic [TS_W-1:0]         wr_ts_i,
  input  logic signed [POS_W-1:0] wr_x_i,
  input  logic signed [POS_W-1:0] wr_y_i,
  input  logic signed [POS_W-1:0] wr_z_i,
  output ref_entry_t              entry_o
);

  localparam int unsigned DEPTH = (TRAJ_COUNT < (1 << IDX_W)) ? TRAJ_COUNT : (1 << IDX_W);
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DEPTH-1:0]        valid_q;
  logic [TS_W-1:0]         ts_q [DEPTH];
  logic signed [POS_W-1:0] x_q  [DEPTH];
  logic signed [POS_W-1:0] y_q  [DEPTH];
  logic signed [POS_W-1:0] z_q  [DEPTH];

  logic [AW-1:0] addr;
  logic          in_range;

  assign addr     = idx_i[AW-1:0];
  assign in_range = ({1'b0, idx_i} < (IDX_W + 1)'(DEPTH));

  always_comb begin
    entry_o.in_range = in_range;
    entry_o.valid    = in_range && valid_q[addr];
    entry_o.ts       = ts_q[addr];
    entry_o.x        = x_q[addr];
    entry_o.y        = y_q[addr];
    entry_o.z        = z_q[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i && in_range) begin
      valid_q[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && in_range) begin
      ts_q[addr] <= wr_ts_i;
      x_q[addr]  <= wr_x_i;
      y_q[addr]  <= wr_y_i;
      z_q[addr]  <= wr_z_i;
    end
  end

endmodule

// ----- design/kts_decide.sv -----
// ----------------------------------------------------------------------------
// Keyframe decision
// Time gap and squared distance tests against the stored reference.
// ----------------------------------------------------------------------------
module kts_decide import kts_pkg::*; (
  input  logic [LEVEL_W-1:0]      level_i,
  input  logic [TS_W-1:0]         ts_i,
  input  logic signed [POS_W-1:0] x_i,
  input  logic signed [POS_W-1:0] y_i,
  input  logic signed [POS_W-1:0] z_i,
  input  ref_entry_t              entry_i,
  input  logic [TGAP_W-1:0]       tgap_thr_i,
  input  logic [DIST_W-1:0]       dist_thr_i,
  output decision_t               dec_o
);

  logic [TS_W-1:0]           gap;
  logic                      c_time;
  logic signed [POS_W:0]     diff_x, diff_y, diff_z;
  logic [POS_W-1:0]          dx, dy, dz;
  logic [2*DIST_W-1:0]       sq_x, sq_y, sq_z, sq_thr;
  logic [2*DIST_W+1:0]       sq_sum;
  logic                      over_axis;
  logic                      c_dist;

  assign gap    = (ts_i >= entry_i.ts) ? (ts_i - entry_i.ts) : (entry_i.ts - ts_i);
  assign c_time = gap > TS_W'(tgap_thr_i);

  assign diff_x = $signed({x_i[POS_W-1], x_i}) - $signed({entry_i.x[POS_W-1], entry_i.x});
  assign diff_y = $signed({y_i[POS_W-1], y_i}) - $signed({entry_i.y[POS_W-1], entry_i.y});
  assign diff_z = $signed({z_i[POS_W-1], z_i}) - $signed({entry_i.z[POS_W-1], entry_i.z});

  assign dx = diff_x[POS_W] ? POS_W'(-diff_x) : diff_x[POS_W-1:0];
  assign dy = diff_y[POS_W] ? POS_W'(-diff_y) : diff_y[POS_W-1:0];
  assign dz = diff_z[POS_W] ? POS_W'(-diff_z) : diff_z[POS_W-1:0];

  assign over_axis = (dx > POS_W'(dist_thr_i)) || (dy > POS_W'(dist_thr_i))
                  || (dz > POS_W'(dist_thr_i));

  // Unless some axis is over the threshold, each difference fits in 31 bits.
  assign sq_x   = (2*DIST_W)'(dx[DIST_W-1:0]) * (2*DIST_W)'(dx[DIST_W-1:0]);
  assign sq_y   = (2*DIST_W)'(dy[DIST_W-1:0]) * (2*DIST_W)'(dy[DIST_W-1:0]);
  assign sq_z   = (2*DIST_W)'(dz[DIST_W-1:0]) * (2*DIST_W)'(dz[DIST_W-1:0]);
  assign sq_thr = (2*DIST_W)'(dist_thr_i) * (2*DIST_W)'(dist_thr_i);
  assign sq_sum = (2*DIST_W+2)'(sq_x) + (2*DIST_W+2)'(sq_y) + (2*DIST_W+2)'(sq_z);
  assign c_dist = over_axis || (sq_sum > (2*DIST_W+2)'(sq_thr));

  always_comb begin
    dec_o.level  = level_i;
    dec_o.stored = 1'b0;
    dec_o.first  = 1'b0;
    if (entry_i.in_range) begin
      if (!entry_i.valid) begin
        dec_o.first  = 1'b1;
        dec_o.stored = 1'b1;
        if (level_i == '0) begin
          dec_o.level = raise_level(level_i);
        end
      end else if (level_i == '0 && (c_time || c_dist)) begin
        dec_o.level  = raise_level(level_i);
        dec_o.stored = 1'b1;
      end
    end
  end

endmodule

// ----- verif/tb_keyframe_time_distance_select.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keyframe time/distance selector testbench
// Feeds pose requests through the valid/ready input, predicts each keyframe
// decision from a private copy of the per-trajectory reference table, and
// compares every returned decision field by field. The thresholds are
// reprogrammed between phases over the APB port, and both sides idle and stall
// at random.
// ----------------------------------------------------------------------------
module tb_keyframe_time_distance_select;
  import kts_pkg::*;

  localparam int unsigned TRAJ_COUNT  = 16;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 150;

  localparam logic [ADDR_W-1:0] TIME_GAP_ADDR = ADDR_W'({REG_TIME_GAP, 3'b000});
  localparam logic [ADDR_W-1:0] DISTANCE_ADDR = ADDR_W'({REG_DISTANCE, 3'b000});

  localparam logic [TS_W-1:0]   TS_TOP     = {TS_W{1'b1}};
  localparam logic [TS_W-1:0]   ONE_SECOND = 63'd1000000000;
  localparam logic [POS_W-1:0]  POS_TOP    = 32'h7fffffff;
  localparam logic [POS_W-1:0]  POS_BOTTOM = 32'h80000000;

  typedef struct packed {
    logic [IDX_W-1:0]   traj;
    logic [LEVEL_W-1:0] level;
    logic [TS_W-1:0]    ts;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [POS_W-1:0]   z;
  } pose_t;

  logic                    clk_i                 = 1'b0;
  logic                    rst_ni                = 1'b0;
  logic                    in_valid_i            = 1'b0;
  logic                    in_ready_o;
  logic [IDX_W-1:0]        trajectory_index_i    = '0;
  logic [LEVEL_W-1:0]      level_in_i            = '0;
  logic [TS_W-1:0]         timestamp_ns_i        = '0;
  logic signed [POS_W-1:0] position_x_i          = '0;
  logic signed [POS_W-1:0] position_y_i          = '0;
  logic signed [POS_W-1:0] position_z_i          = '0;
  logic                    out_valid_o;
  logic                    out_ready_i           = 1'b0;
  logic [LEVEL_W-1:0]      level_out_o;
  logic                    became_reference_o;
  logic                    first_of_trajectory_o;
  logic                    psel                  = 1'b0;
  logic                    penable               = 1'b0;
  logic                    pwrite                = 1'b0;
  logic [ADDR_W-1:0]       paddr                 = '0;
  logic [CFG_W-1:0]        pwdata                = '0;
  logic [CFG_W-1:0]        prdata;
  logic                    pready;

  keyframe_time_distance_select #(
    .TRAJ_COUNT(TRAJ_COUNT)
  ) dut (.*);

  pose_t       pending_poses[$];
  decision_t   expected_decisions[$];

  logic [TGAP_W-1:0] time_gap_limit = TGAP_RESET;
  logic [DIST_W-1:0] distance_limit = DIST_RESET;

  logic              kf_valid [TRAJ_COUNT] = '{default: 1'b0};
  logic [TS_W-1:0]   kf_ts    [TRAJ_COUNT] = '{default: '0};
  logic [POS_W-1:0]  kf_x     [TRAJ_COUNT] = '{default: '0};
  logic [POS_W-1:0]  kf_y     [TRAJ_COUNT] = '{default: '0};
  logic [POS_W-1:0]  kf_z     [TRAJ_COUNT] = '{default: '0};

  logic [TS_W-1:0]   last_ts  [TRAJ_COUNT] = '{default: '0};
  logic [POS_W-1:0]  last_x   [TRAJ_COUNT] = '{default: '0};
  logic [POS_W-1:0]  last_y   [TRAJ_COUNT] = '{default: '0};
  logic [POS_W-1:0]  last_z   [TRAJ_COUNT] = '{default: '0};

  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_idle_pct = 0;
  int unsigned mismatch_count    = 0;
  int unsigned cycle_count       = 0;
  int unsigned hold_left         = 0;
  logic        hold_token        = 1'b0;
  logic        hold_seen         = 1'b0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [LEVEL_W-1:0] raised_level(input logic [LEVEL_W-1:0] lvl);
    return (lvl == LEVEL_MAX) ? LEVEL_MAX : lvl + 1'b1;
  endfunction

  function automatic logic [63:0] random64();
    return {$urandom, $urandom};
  endfunction

  // Works out the decision for one pose and updates the reference table.
  function automatic decision_t select_keyframe(input pose_t p);
    decision_t                d;
    logic [TS_W-1:0]          gap;
    logic signed [POS_W:0]    dx, dy, dz;
    logic [POS_W:0]           mx, my, mz;
    logic [2*POS_W+3:0]       dist_sq;
    logic [2*POS_W+3:0]       limit_sq;
    d.level  = p.level;
    d.stored = 1'b0;
    d.first  = 1'b0;
    if (!kf_valid[p.traj]) begin
      d.first  = 1'b1;
      d.stored = 1'b1;
      if (p.level == '0) d.level = raised_level(p.level);
    end else if (p.level == '0) begin
      gap = (p.ts >= kf_ts[p.traj]) ? p.ts - kf_ts[p.traj] : kf_ts[p.traj] - p.ts;
      dx = {p.x[POS_W-1], p.x} - {kf_x[p.traj][POS_W-1], kf_x[p.traj]};
      dy = {p.y[POS_W-1], p.y} - {kf_y[p.traj][POS_W-1], kf_y[p.traj]};
      dz = {p.z[POS_W-1], p.z} - {kf_z[p.traj][POS_W-1], kf_z[p.traj]};
      mx = (dx < 0) ? -dx : dx;
      my = (dy < 0) ? -dy : dy;
      mz = (dz < 0) ? -dz : dz;
      dist_sq = 68'(mx) * 68'(mx) + 68'(my) * 68'(my) + 68'(mz) * 68'(mz);
      limit_sq = 68'(distance_limit) * 68'(distance_limit);
      if (gap > TS_W'(time_gap_limit) || dist_sq > limit_sq) begin
        d.level  = raised_level(p.level);
        d.stored = 1'b1;
      end
    end
    if (d.stored) begin
      kf_valid[p.traj] = 1'b1;
      kf_ts[p.traj]    = p.ts;
      kf_x[p.traj]     = p.x;
      kf_y[p.traj]     = p.y;
      kf_z[p.traj]     = p.z;
    end
    return d;
  endfunction

  function automatic void push_pose(input logic [IDX_W-1:0] traj,
                                    input logic [LEVEL_W-1:0] level,
                                    input logic [TS_W-1:0] ts,
                                    input logic [POS_W-1:0] x,
                                    input logic [POS_W-1:0] y,
                                    input logic [POS_W-1:0] z);
    pending_poses.push_back('{traj, level, ts, x, y, z});
    last_ts[traj] = ts;
    last_x[traj]  = x;
    last_y[traj]  = y;
    last_z[traj]  = z;
  endfunction

  // Mostly lands within one threshold of the base on this axis.
  function automatic logic [POS_W-1:0] near_coord(input logic [POS_W-1:0] base);
    logic [63:0] reach;
    reach = 64'(distance_limit);
    if ($urandom_range(99) < 12) return $urandom;
    return POS_W'(64'(base) + (random64() % (2 * reach + 1)) - reach);
  endfunction

  task automatic push_random_poses(input int count);
    logic [IDX_W-1:0]   traj;
    logic [LEVEL_W-1:0] level;
    logic [TS_W-1:0]    ts;
    logic [63:0]        reach;
    logic [63:0]        advance;
    int unsigned        pick;
    repeat (count) begin
      traj  = ($urandom_range(1) == 0) ? IDX_W'($urandom_range(3)) : IDX_W'($urandom);
      level = ($urandom_range(9) < 7) ? '0 : LEVEL_W'($urandom);
      reach = 64'(time_gap_limit);
      pick  = $urandom_range(9);
      case (pick)
        0:       advance = reach;
        1:       advance = reach + 1;
        2:       advance = 64'($urandom_range(3));
        default: advance = random64() % (2 * reach + 2);
      endcase
      if (pick == 9) begin
        ts = TS_W'(random64());
      end else if ($urandom_range(4) == 0) begin
        ts = last_ts[traj] - TS_W'(advance);
      end else begin
        ts = last_ts[traj] + TS_W'(advance);
      end
      pick = $urandom_range(9);
      if (pick == 0) begin
        push_pose(traj, level, ts, last_x[traj] + POS_W'(distance_limit),
                  last_y[traj], last_z[traj]);
      end else if (pick == 1) begin
        push_pose(traj, level, ts, last_x[traj], last_y[traj],
                  last_z[traj] - POS_W'(distance_limit) - 1'b1);
      end else begin
        push_pose(traj, level, ts, near_coord(last_x[traj]), near_coord(last_y[traj]),
                  near_coord(last_z[traj]));
      end
    end
  endtask

  task automatic check_register(input logic [ADDR_W-1:0] addr,
                                input logic [CFG_W-1:0] value,
                                input int unsigned width);
    logic [CFG_W-1:0] mask;
    mask = (width >= CFG_W) ? '1 : ((64'd1 << width) - 1);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if ((prdata & mask) !== (value & mask)) begin
      $display("%0t: register at %0d expected %0d actual %0d", $time, addr,
               value & mask, prdata & mask);
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_register(input logic [ADDR_W-1:0] addr,
                                input logic [CFG_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == TIME_GAP_ADDR) begin
      time_gap_limit = value[TGAP_W-1:0];
      check_register(addr, value, TGAP_W);
    end else begin
      distance_limit = value[DIST_W-1:0];
      check_register(addr, value, DIST_W);
    end
  endtask

  task automatic set_idling(input int unsigned sender_pct, input int unsigned receiver_pct);
    @(posedge clk_i);
    sender_idle_pct   <= sender_pct;
    receiver_idle_pct <= receiver_pct;
  endtask

  task automatic wait_until_idle();
    do @(negedge clk_i);
    while (pending_poses.size() != 0 || in_valid_i || expected_decisions.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : drive_poses
    pose_t next_pose;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_decisions.push_back(select_keyframe(pose_t'{trajectory_index_i, level_in_i,
            timestamp_ns_i, position_x_i, position_y_i, position_z_i}));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_poses.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_pose = pending_poses.pop_front();
          trajectory_index_i <= next_pose.traj;
          level_in_i         <= next_pose.level;
          timestamp_ns_i     <= next_pose.ts;
          position_x_i       <= next_pose.x;
          position_y_i       <= next_pose.y;
          position_z_i       <= next_pose.z;
          in_valid_i         <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : collect_decisions
    decision_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_decisions.size() == 0) begin
          $display("%0t: decision with no request waiting, expected none actual %0d/%0d/%0d",
                   $time, level_out_o, became_reference_o, first_of_trajectory_o);
          mismatch_count++;
        end else begin
          want = expected_decisions.pop_front();
          if (level_out_o !== want.level) begin
            $display("%0t: level_out expected %0d actual %0d", $time, want.level, level_out_o);
            mismatch_count++;
          end
          if (became_reference_o !== want.stored) begin
            $display("%0t: became_reference expected %0d actual %0d", $time, want.stored,
                     became_reference_o);
            mismatch_count++;
          end
          if (first_of_trajectory_o !== want.first) begin
            $display("%0t: first_of_trajectory expected %0d actual %0d", $time, want.first,
                     first_of_trajectory_o);
            mismatch_count++;
          end
        end
      end
      if (hold_token != hold_seen) begin
        hold_seen <= hold_token;
        hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
      out_ready_i <= (hold_token == hold_seen) && (hold_left == 0) &&
                     ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : run_regression
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    check_register(TIME_GAP_ADDR, 64'(TGAP_RESET), TGAP_W);
    check_register(DISTANCE_ADDR, 64'(DIST_RESET), DIST_W);

    // Reset thresholds: one second and a distance of 65536.
    set_idling(25, 51);
    push_pose(4'd0, 3'd0, '0, 32'd0, 32'd0, 32'd0);
    push_pose(4'd1, 3'd7, TS_TOP, POS_TOP, POS_BOTTOM, 32'd0);
    push_pose(4'd2, 3'd3, 63'd12345, -32'sd5, 32'sd5, -32'sd5);
    push_pose(4'd0, 3'd0, ONE_SECOND, 32'd0, 32'd0, 32'd0);
    push_pose(4'd0, 3'd0, ONE_SECOND + 1'b1, 32'd0, 32'd0, 32'd0);
    push_pose(4'd0, 3'd0, ONE_SECOND + 1'b1, 32'd65536, 32'd0, 32'd0);
    push_pose(4'd0, 3'd0, ONE_SECOND + 1'b1, 32'd0, 32'd0, -32'sd65537);
    push_pose(4'd0, 3'd0, ONE_SECOND + 1'b1, 32'd40000, 32'd40000, -32'sd25537);
    push_pose(4'd0, 3'd5, 63'd5000000000000, 32'd0, 32'd0, 32'd0);
    push_pose(4'd1, 3'd0, '0, POS_TOP, POS_BOTTOM, 32'd0);
    push_pose(4'd1, 3'd0, '0, POS_BOTTOM, POS_TOP, 32'd0);
    push_pose(4'd15, 3'd0, TS_TOP, 32'hffffffff, 32'd0, POS_TOP);
    push_pose(4'd15, 3'd0, TS_TOP - ONE_SECOND - 1'b1, 32'hffffffff, 32'd0, POS_TOP);
    push_pose(4'd15, 3'd7, '0, 32'd0, 32'd0, 32'd0);
    push_pose(4'd2, 3'd0, 63'd12345, -32'sd5, 32'sd5, -32'sd5);
    push_pose(4'd2, 3'd1, 63'd99, 32'd0, 32'd0, 32'd0);
    push_random_poses(240);
    wait_until_idle();

    // Zero thresholds: any change at all promotes a level-zero pose.
    write_register(TIME_GAP_ADDR, '0);
    write_register(DISTANCE_ADDR, '0);
    set_idling(51, 25);
    push_pose(4'd2, 3'd0, 63'd12345, -32'sd5, 32'sd5, -32'sd5);
    push_pose(4'd2, 3'd0, 63'd12346, -32'sd5, 32'sd5, -32'sd5);
    push_pose(4'd2, 3'd0, 63'd12346, -32'sd4, 32'sd5, -32'sd5);
    push_random_poses(200);
    wait_until_idle();

    write_register(TIME_GAP_ADDR, 64'(TGAP_W'('1)));
    write_register(DISTANCE_ADDR, 64'(DIST_W'('1)));
    push_random_poses(200);
    wait_until_idle();

    // Typical tracking thresholds, then a long stall at the result side.
    write_register(TIME_GAP_ADDR, 64'd2000000);
    write_register(DISTANCE_ADDR, 64'd19661);
    set_idling(0, 0);
    push_random_poses(300);
    @(posedge clk_i);
    hold_token <= ~hold_token;
    wait_until_idle();

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/kts_pkg.sv
design/kts_table.sv
design/kts_decide.sv
design/keyframe_time_distance_select.sv
verif/tb_keyframe_time_distance_select.sv
